### hw/rtl/feed_sequence_dedup_filter_top_defines.svh
// Assertion macros for the dedup filter.
// Taken in by `include in the files that carry assertions; no dependencies.
`ifndef FEED_SEQUENCE_DEDUP_FILTER_TOP_DEFINES_SVH
`define FEED_SEQUENCE_DEDUP_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the dedup filter.
// No dependencies.
package sdf_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CHAN_W      = 16;
  localparam int SEQ_W       = 32;
  localparam int KEY_W       = CHAN_W + SEQ_W;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W       = 9;
  localparam int VERD_W      = 3;
  localparam int GRP         = 16;
  localparam int NGRP        = (TABLE_DEPTH + GRP - 1) / GRP;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIM  = 2'd2;

  localparam logic [LIM_W-1:0] WIN_LIM_RST = 9'd200;

  localparam logic [VERD_W-1:0] V_NEW      = 3'd0;
  localparam logic [VERD_W-1:0] V_BYPASS   = 3'd1;
  localparam logic [VERD_W-1:0] V_DUP      = 3'd2;
  localparam logic [VERD_W-1:0] V_BADHDR   = 3'd3;
  localparam logic [VERD_W-1:0] V_DISABLED = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_EVT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
  } cell_cmd_t;

  typedef struct packed {
    logic              vld;
    logic              lt;
    logic [KEY_W-1:0]  key;
  } cell_link_t;

  typedef struct packed {
    logic hit;
    logic min_lt;
  } sdf_stat_t;

endpackage

### hw/rtl/sdf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for packet headers and verdicts.
// Depends on sdf_pkg.
interface sdf_in_if;
  logic                        valid;
  logic                        ready;
  logic [sdf_pkg::CHAN_W-1:0]  channel_number;
  logic [sdf_pkg::SEQ_W-1:0]   sequence_number;
  logic                        header_ok;
  logic                        from_retransmit;

  modport source (output valid, channel_number, sequence_number, header_ok,
                  from_retransmit, input ready);
  modport sink (input valid, channel_number, sequence_number, header_ok,
                from_retransmit, output ready);
endinterface

interface sdf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        forward;
  logic [sdf_pkg::VERD_W-1:0]  verdict;

  modport source (output valid, forward, verdict, input ready);
  modport sink (input valid, forward, verdict, output ready);
endinterface

### hw/rtl/sdf_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted key row: holds one key, compares, shifts up or down.
// Depends on sdf_pkg.
module sdf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sdf_pkg::cell_cmd_t  cmd,
  input  sdf_pkg::cell_link_t lo_i,
  input  sdf_pkg::cell_link_t hi_i,
  output sdf_pkg::cell_link_t link_o,
  output logic                eq_o
);

  localparam int KEY_W = sdf_pkg::KEY_W;

  logic             vld_r, vld_nxt;
  logic             lt_r, lt_nxt;
  logic             eq_r, eq_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  always_comb begin
    vld_nxt = vld_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    unique case (cmd.op)
      sdf_pkg::CELL_CMP: begin
        lt_nxt = !vld_r || (cmd.key < key_r);
        eq_nxt = vld_r && (cmd.key == key_r);
      end
      sdf_pkg::CELL_INS: begin
        if (lt_r) begin
          if (lo_i.lt) begin
            key_nxt = lo_i.key;
            vld_nxt = lo_i.vld;
          end else begin
            key_nxt = cmd.key;
            vld_nxt = 1'b1;
          end
        end
      end
      sdf_pkg::CELL_EVT: begin
        key_nxt = hi_i.key;
        vld_nxt = hi_i.vld;
        lt_nxt  = hi_i.lt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      lt_r  <= 1'b0;
      eq_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link_o.vld = vld_r;
  assign link_o.lt  = lt_r;
  assign link_o.key = key_r;
  assign eq_o       = eq_r;

endmodule

### hw/rtl/sdf_hit_tree.sv
`timescale 1ns / 1ps
// Registered OR tree over the per-cell match flags.
// Depends on sdf_pkg.
module sdf_hit_tree (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sdf_pkg::TABLE_DEPTH-1:0] eq_i,
  output logic                            hit_o
);

  localparam int GRP   = sdf_pkg::GRP;
  localparam int NGRP  = sdf_pkg::NGRP;
  localparam int PAD_W = NGRP * GRP;

  logic [PAD_W-1:0] eq_pad;
  logic [NGRP-1:0]  grp_r, grp_nxt;

  assign eq_pad = PAD_W'(eq_i);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = |eq_pad[g*GRP +: GRP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
    end else begin
      grp_r <= grp_nxt;
    end
  end

  assign hit_o = |grp_r;

endmodule

### hw/rtl/sdf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: config registers, item decode, key count, cell commands, result register.
// Depends on sdf_pkg, sdf_if and the assertion macro header.
`include "feed_sequence_dedup_filter_top_defines.svh"
module sdf_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  sdf_in_if.sink                          in_ch,
  sdf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  sdf_pkg::sdf_stat_t              stat,
  output sdf_pkg::cell_cmd_t              cmd
);

  localparam int KEY_W  = sdf_pkg::KEY_W;
  localparam int CNT_W  = sdf_pkg::CNT_W;
  localparam int LIM_W  = sdf_pkg::LIM_W;
  localparam int VERD_W = sdf_pkg::VERD_W;
  localparam int CW     = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sdf_pkg::TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_EVT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic              blk_en_r, ddp_en_r;
  logic [LIM_W-1:0]  win_lim_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              full_path_r, full_path_nxt;
  logic              res_fwd_r, res_fwd_nxt;
  logic [VERD_W-1:0] res_verd_r, res_verd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_fwd_r, out_fwd_nxt;
  logic [VERD_W-1:0] out_verd_r, out_verd_nxt;

  logic          in_acc;
  logic          out_free;
  logic          full;
  logic          over_lim;
  logic [CW-1:0] cnt_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (count_r == FULL_CNT);
  assign cnt_inc     = CW'(count_r) + CW'(1);
  assign over_lim    = (cnt_inc > CW'(win_lim_r));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    full_path_nxt = full_path_r;
    res_fwd_nxt   = res_fwd_r;
    res_verd_nxt  = res_verd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_fwd_nxt   = out_fwd_r;
    out_verd_nxt  = out_verd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt   = {in_ch.channel_number, in_ch.sequence_number};
          state_nxt = S_DONE;
          if (!blk_en_r) begin
            res_fwd_nxt  = 1'b0;
            res_verd_nxt = sdf_pkg::V_DISABLED;
          end else if (!in_ch.header_ok) begin
            res_fwd_nxt  = 1'b0;
            res_verd_nxt = sdf_pkg::V_BADHDR;
          end else if (!ddp_en_r || in_ch.from_retransmit) begin
            res_fwd_nxt  = 1'b1;
            res_verd_nxt = sdf_pkg::V_BYPASS;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: state_nxt = S_RED;
      S_RED: state_nxt = S_DEC;
      S_DEC: begin
        if (stat.hit) begin
          res_fwd_nxt  = 1'b0;
          res_verd_nxt = sdf_pkg::V_DUP;
          state_nxt    = S_DONE;
        end else begin
          res_fwd_nxt  = 1'b1;
          res_verd_nxt = sdf_pkg::V_NEW;
          if (!full) begin
            full_path_nxt = 1'b0;
            state_nxt     = S_INS;
          end else if (stat.min_lt) begin
            state_nxt = S_DONE;
          end else begin
            full_path_nxt = 1'b1;
            state_nxt     = S_EVT;
          end
        end
      end
      S_INS: begin
        count_nxt = count_r + CNT_W'(1);
        state_nxt = (!full_path_r && over_lim) ? S_EVT : S_DONE;
      end
      S_EVT: begin
        count_nxt = count_r - CNT_W'(1);
        state_nxt = full_path_r ? S_INS : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fwd_nxt   = res_fwd_r;
          out_verd_nxt  = res_verd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.key = key_r;
    unique case (state_r)
      S_CMP:   cmd.op = sdf_pkg::CELL_CMP;
      S_INS:   cmd.op = sdf_pkg::CELL_INS;
      S_EVT:   cmd.op = sdf_pkg::CELL_EVT;
      default: cmd.op = sdf_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      full_path_r <= 1'b0;
      out_valid_r <= 1'b0;
      blk_en_r    <= 1'b0;
      ddp_en_r    <= 1'b0;
      win_lim_r   <= sdf_pkg::WIN_LIM_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      full_path_r <= full_path_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sdf_pkg::CFG_BLOCK_EN: blk_en_r  <= cfg_data[0];
          sdf_pkg::CFG_DEDUP_EN: ddp_en_r  <= cfg_data[0];
          sdf_pkg::CFG_WIN_LIM:  win_lim_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    res_fwd_r  <= res_fwd_nxt;
    res_verd_r <= res_verd_nxt;
    out_fwd_r  <= out_fwd_nxt;
    out_verd_r <= out_verd_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.forward = out_fwd_r;
  assign out_ch.verdict = out_verd_r;

  `SDF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT, "key count above depth")
  `SDF_ASSERT_IMP(a_evict_nonempty, clk, rst_n, state_r == S_EVT, count_r != '0, "evict on empty row")
  `SDF_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc, state_r != S_IDLE, "idle after accept")

endmodule

### hw/rtl/feed_sequence_dedup_filter_top.sv
`timescale 1ns / 1ps
// Sequence-number dedup filter: a packet header in, a forward flag and verdict out.
// Channels: in_ch (valid/ready, header fields), out_ch (valid/ready, forward, verdict).
// Configuration: cfg_we/cfg_index/cfg_data write block_enable (0), dedup_enable (1)
// and window_limit (2); write only while no item is in flight.
// Keys (channel, sequence) sit sorted ascending in a row of cells, smallest in cell 0.
// A lookup broadcasts the key to every cell for a compare, ORs the match flags in a
// registered tree, then inserts by shifting cells up and evicts by shifting down.
// Timing: disabled, bad-header and bypass items go from accept through the done state
// to the output register; duplicates also pass compare, reduce and decide states;
// new keys may also take insert and evict steps. One item is in work at a time: a new
// item is accepted only after the last one leaves the done state.
// A result waiting in the output register does not hold off the next accept;
// only a second finished result waits until out_ch takes the first.
// Reset: the row empties, key count zero, block and dedup off, window limit 200.
// Depends on sdf_pkg, sdf_if, sdf_cell, sdf_hit_tree and sdf_ctrl.
module feed_sequence_dedup_filter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  sdf_in_if.sink                          in_ch,
  sdf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = sdf_pkg::TABLE_DEPTH;

  sdf_pkg::cell_cmd_t  cmd;
  sdf_pkg::sdf_stat_t  stat;
  sdf_pkg::cell_link_t link [DEPTH];
  sdf_pkg::cell_link_t link_bot;
  sdf_pkg::cell_link_t link_top;
  logic [DEPTH-1:0]    eq;
  logic                hit;

  assign link_bot = '{vld: 1'b0, lt: 1'b0, key: '0};
  assign link_top = '{vld: 1'b0, lt: 1'b1, key: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdf_pkg::cell_link_t lo, hi;
    if (i == 0) begin : g_lo_edge
      assign lo = link_bot;
    end else begin : g_lo_mid
      assign lo = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi = link_top;
    end else begin : g_hi_mid
      assign hi = link[i+1];
    end
    sdf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .lo_i   (lo),
      .hi_i   (hi),
      .link_o (link[i]),
      .eq_o   (eq[i])
    );
  end

  sdf_hit_tree u_hit (
    .clk   (clk),
    .rst_n (rst_n),
    .eq_i  (eq),
    .hit_o (hit)
  );

  assign stat.hit    = hit;
  assign stat.min_lt = link[0].lt;

  sdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

endmodule
